// ===== src/pxr_pkg.sv =====
// Shared types, constants and arithmetic helpers for the pivot XYZ rotation pipeline.
`default_nettype none

package pxr_pkg;

    localparam int CW  = 24;
    localparam int TW  = 16;
    localparam int TF  = 14;
    localparam int DW  = CW + 1;
    localparam int NTW = TW + 1;
    localparam int PW  = DW + NTW;
    localparam int RTW = PW - TF;
    localparam int SW  = RTW + 2;
    localparam int IDXW = 3;

    typedef logic signed [CW-1:0]  coord_t;
    typedef logic signed [TW-1:0]  trig_t;
    typedef logic signed [NTW-1:0] ntrig_t;
    typedef logic signed [DW-1:0]  diff_t;
    typedef logic signed [PW-1:0]  prod_t;
    typedef logic signed [RTW-1:0] term_t;
    typedef logic signed [SW-1:0]  sum_t;

    localparam trig_t  TRIG_ONE  = TW'(1 << TF);
    localparam prod_t  RND_HALF  = PW'(1) << (TF - 1);
    localparam coord_t COORD_MAX = {1'b0, {(CW - 1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(CW - 1){1'b0}}};

    typedef enum logic [IDXW-1:0] {
        REG_COS_X   = 3'd0,
        REG_SIN_X   = 3'd1,
        REG_COS_Y   = 3'd2,
        REG_SIN_Y   = 3'd3,
        REG_COS_Z   = 3'd4,
        REG_SIN_Z   = 3'd5,
        REG_PIVOT_X = 3'd6,
        REG_PIVOT_Y = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        coord_t in_x;
        coord_t in_y;
        coord_t in_z;
    } point_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
    } result_t;

    // Round to nearest, ties towards plus infinity
    function automatic term_t round_term(prod_t p);
        prod_t r;
        r = p + RND_HALF;
        return r[PW-1:TF];
    endfunction

    function automatic coord_t saturate(sum_t v);
        coord_t r;
        priority if (v > sum_t'(COORD_MAX))
        begin
            r = COORD_MAX;
        end
        else if (v < sum_t'(COORD_MIN))
        begin
            r = COORD_MIN;
        end
        else
        begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/pivot_xyz_rotation.sv =====
// Top level: configuration registers and three chained pivot rotations (X, Y, Z).
//
// Usage:
//   Point channel (pt_valid, pt_stall, pt): one transaction carries x, y, z of a
//   point in signed Q16.8. Result channel (res_valid, res_stall, res): one
//   transaction carries the rotated and saturated x and y; z is dropped.
//   Configuration: cfg_write with cfg_index and cfg_data writes one register
//   (cos/sin of each axis in Q1.14, pivot x and y in Q16.8). Write only while idle.
//   Pipeline: pivot subtract, multiply and round-add-saturate stages per rotation.
//   Throughput: one point per cycle unless a result is held by res_stall, set by
//   the single shared pipeline enable.
//   Receiver stall: the whole pipeline holds, and pt_stall rises while a result
//   waits on res_stall; empty stages hold as well, so no transaction is lost.
//   Reset: all stages empty, every cosine 1.0, every sine and both pivots 0.
`default_nettype none

module pivot_xyz_rotation (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [pxr_pkg::IDXW-1:0]       cfg_index,
    input  wire logic [pxr_pkg::CW-1:0]         cfg_data,
    input  wire logic                           pt_valid,
    output logic                                pt_stall,
    input  wire pxr_pkg::point_t                pt,
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output pxr_pkg::result_t                    res
);

    pxr_pkg::trig_t  cos_x_reg;
    pxr_pkg::trig_t  sin_x_reg;
    pxr_pkg::trig_t  cos_y_reg;
    pxr_pkg::trig_t  sin_y_reg;
    pxr_pkg::trig_t  cos_z_reg;
    pxr_pkg::trig_t  sin_z_reg;
    pxr_pkg::coord_t pivot_x_reg;
    pxr_pkg::coord_t pivot_y_reg;

    logic            advance;
    logic            vx;
    logic            vy;
    pxr_pkg::coord_t x1;
    pxr_pkg::coord_t y1;
    pxr_pkg::coord_t z1;
    pxr_pkg::coord_t x2;
    pxr_pkg::coord_t y2;
    pxr_pkg::coord_t z2;
    pxr_pkg::coord_t x3;
    pxr_pkg::coord_t y3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_x_reg   <= pxr_pkg::TRIG_ONE;
            sin_x_reg   <= '0;
            cos_y_reg   <= pxr_pkg::TRIG_ONE;
            sin_y_reg   <= '0;
            cos_z_reg   <= pxr_pkg::TRIG_ONE;
            sin_z_reg   <= '0;
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (pxr_pkg::cfg_reg_e'(cfg_index))
                pxr_pkg::REG_COS_X:   cos_x_reg   <= cfg_data[pxr_pkg::TW-1:0];
                pxr_pkg::REG_SIN_X:   sin_x_reg   <= cfg_data[pxr_pkg::TW-1:0];
                pxr_pkg::REG_COS_Y:   cos_y_reg   <= cfg_data[pxr_pkg::TW-1:0];
                pxr_pkg::REG_SIN_Y:   sin_y_reg   <= cfg_data[pxr_pkg::TW-1:0];
                pxr_pkg::REG_COS_Z:   cos_z_reg   <= cfg_data[pxr_pkg::TW-1:0];
                pxr_pkg::REG_SIN_Z:   sin_z_reg   <= cfg_data[pxr_pkg::TW-1:0];
                pxr_pkg::REG_PIVOT_X: pivot_x_reg <= cfg_data;
                pxr_pkg::REG_PIVOT_Y: pivot_y_reg <= cfg_data;
            endcase
        end
    end

    // Advance whenever the output slot is empty or being taken
    assign advance  = !res_valid || !res_stall;
    assign pt_stall = !advance;

    // X: rotate (y, z), x passes
    pxr_rotate u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .valid_in  (pt_valid),
        .a         (pt.in_y),
        .b         (pt.in_z),
        .pass_in   (pt.in_x),
        .piv_a     (pivot_y_reg),
        .piv_b     ('0),
        .cos_v     (cos_x_reg),
        .sin_v     (sin_x_reg),
        .valid_out (vx),
        .a_out     (y1),
        .b_out     (z1),
        .pass_out  (x1)
    );

    // Y: rotate (z, x), y passes
    pxr_rotate u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .valid_in  (vx),
        .a         (z1),
        .b         (x1),
        .pass_in   (y1),
        .piv_a     ('0),
        .piv_b     (pivot_x_reg),
        .cos_v     (cos_y_reg),
        .sin_v     (sin_y_reg),
        .valid_out (vy),
        .a_out     (z2),
        .b_out     (x2),
        .pass_out  (y2)
    );

    // Z: rotate (x, y), drop z
    pxr_rotate u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .valid_in  (vy),
        .a         (x2),
        .b         (y2),
        .pass_in   (z2),
        .piv_a     (pivot_x_reg),
        .piv_b     (pivot_y_reg),
        .cos_v     (cos_z_reg),
        .sin_v     (sin_z_reg),
        .valid_out (res_valid),
        .a_out     (x3),
        .b_out     (y3),
        .pass_out  ()
    );

    assign res.out_x = x3;
    assign res.out_y = y3;

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pt_stall |-> (res_valid && res_stall))
        else $error("point channel stalled without a waiting result");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> res_valid)
        else $error("stalled result dropped");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> $stable(res))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== src/pxr_rotate.sv =====
// One plane rotation about a pivot: subtract, multiply, round-sum-saturate in three stages.
`default_nettype none

module pxr_rotate (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           valid_in,
    input  wire pxr_pkg::coord_t a,
    input  wire pxr_pkg::coord_t b,
    input  wire pxr_pkg::coord_t pass_in,
    input  wire pxr_pkg::coord_t piv_a,
    input  wire pxr_pkg::coord_t piv_b,
    input  wire pxr_pkg::trig_t  cos_v,
    input  wire pxr_pkg::trig_t  sin_v,
    output logic                valid_out,
    output pxr_pkg::coord_t     a_out,
    output pxr_pkg::coord_t     b_out,
    output pxr_pkg::coord_t     pass_out
);

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    pxr_pkg::diff_t  da_reg;
    pxr_pkg::diff_t  db_reg;
    pxr_pkg::coord_t p1_reg;
    pxr_pkg::prod_t  ac_reg;
    pxr_pkg::prod_t  bns_reg;
    pxr_pkg::prod_t  as_reg;
    pxr_pkg::prod_t  bc_reg;
    pxr_pkg::coord_t p2_reg;
    pxr_pkg::coord_t a3_reg;
    pxr_pkg::coord_t b3_reg;
    pxr_pkg::coord_t p3_reg;

    pxr_pkg::diff_t  da_next;
    pxr_pkg::diff_t  db_next;
    pxr_pkg::ntrig_t ncos;
    pxr_pkg::ntrig_t nsin;
    pxr_pkg::ntrig_t nsin_neg;
    pxr_pkg::sum_t   sa_next;
    pxr_pkg::sum_t   sb_next;

    assign da_next  = pxr_pkg::diff_t'(a) - pxr_pkg::diff_t'(piv_a);
    assign db_next  = pxr_pkg::diff_t'(b) - pxr_pkg::diff_t'(piv_b);
    assign ncos     = pxr_pkg::ntrig_t'(cos_v);
    assign nsin     = pxr_pkg::ntrig_t'(sin_v);
    assign nsin_neg = -nsin;

    assign sa_next = pxr_pkg::sum_t'(pxr_pkg::round_term(ac_reg))
                   + pxr_pkg::sum_t'(pxr_pkg::round_term(bns_reg))
                   + pxr_pkg::sum_t'(piv_a);
    assign sb_next = pxr_pkg::sum_t'(pxr_pkg::round_term(as_reg))
                   + pxr_pkg::sum_t'(pxr_pkg::round_term(bc_reg))
                   + pxr_pkg::sum_t'(piv_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            da_reg  <= da_next;
            db_reg  <= db_next;
            p1_reg  <= pass_in;
            ac_reg  <= da_reg * ncos;
            bns_reg <= db_reg * nsin_neg;
            as_reg  <= da_reg * nsin;
            bc_reg  <= db_reg * ncos;
            p2_reg  <= p1_reg;
            a3_reg  <= pxr_pkg::saturate(sa_next);
            b3_reg  <= pxr_pkg::saturate(sb_next);
            p3_reg  <= p2_reg;
        end
    end

    assign valid_out = v3_reg;
    assign a_out     = a3_reg;
    assign b_out     = b3_reg;
    assign pass_out  = p3_reg;

`ifndef SYNTHESIS
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (en && valid_in) |=> v1_reg)
        else $error("accepted transaction did not enter the first stage");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(v1_reg) && $stable(v2_reg) && $stable(v3_reg)
                 && $stable(a3_reg) && $stable(b3_reg)))
        else $error("pipeline moved while held");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v2_reg) |=> (v3_reg && p3_reg == $past(p2_reg)))
        else $error("transaction lost between second and third stage");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for pivot_xyz_rotation: directed table, random phases, predictor.
`default_nettype none

module testbench;

    localparam int HALF_PERIOD = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_LEN    = 250;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 105;
    localparam int DIR_ROWS    = 6;
    localparam int DIR_SETS    = 3;

    typedef enum int { RX_FREE, RX_RANDOM, RX_RUNS } rx_mode_e;
    typedef enum int { TX_STREAM, TX_BURSTS } tx_style_e;
    typedef enum int { CFG_RANDOM, CFG_EXTREME, CFG_RAW16, CFG_NEAR } cfg_kind_e;

    typedef struct packed {
        pxr_pkg::point_t  pnt;
        pxr_pkg::result_t want;
    } dir_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    logic [pxr_pkg::IDXW-1:0]   cfg_index;
    logic [pxr_pkg::CW-1:0]     cfg_data;
    logic                       pt_valid;
    logic                       pt_stall;
    pxr_pkg::point_t            pt;
    logic                       res_valid;
    logic                       res_stall;
    pxr_pkg::result_t           res;

    pxr_pkg::trig_t             trig_reg [6];
    pxr_pkg::coord_t            pivot_x_reg;
    pxr_pkg::coord_t            pivot_y_reg;
    pxr_pkg::result_t           pending_xy [$];
    pxr_pkg::result_t           oldest;
    logic [pxr_pkg::CW-1:0]     cfg_vals [8];
    int                         fail_count;
    int                         cycles;
    rx_mode_e                   rx_mode;
    tx_style_e                  tx_style;
    int                         hold_req;
    int                         hold_done;
    int                         hold_left;
    int                         run_left;
    logic                       run_stall;
    int                         burst_left;

    // Identity rows: under reset settings x and y pass straight through
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{ '{24'sh000000, 24'sh000000, 24'sh000000}, '{24'sh000000, 24'sh000000} },
        '{ '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF}, '{24'sh7FFFFF, 24'sh7FFFFF} },
        '{ '{24'sh800000, 24'sh800000, 24'sh800000}, '{24'sh800000, 24'sh800000} },
        '{ '{24'sh000001, 24'shFFFFFF, 24'sh000001}, '{24'sh000001, 24'shFFFFFF} },
        '{ '{24'sh7FFFFF, 24'sh800000, 24'sh000000}, '{24'sh7FFFFF, 24'sh800000} },
        '{ '{24'sh123456, 24'shFFDCBB, 24'sh007654}, '{24'sh123456, 24'shFFDCBB} }
    };

    // Half-angle ties, unit extremes with far pivots, out-of-range raw trig
    logic [pxr_pkg::CW-1:0] dir_cfg [DIR_SETS][8] = '{
        '{24'h002000, 24'h002000, 24'h002000, 24'h002000,
          24'h002000, 24'h002000, 24'h000100, 24'hFFFF00},
        '{24'hFFC000, 24'h004000, 24'hFFC000, 24'h004000,
          24'hFFC000, 24'h004000, 24'h7FFFFF, 24'h800000},
        '{24'h007FFF, 24'hFF8000, 24'h007FFF, 24'hFF8000,
          24'h007FFF, 24'hFF8000, 24'h800000, 24'h7FFFFF}
    };

    pivot_xyz_rotation u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pt_valid  (pt_valid),
        .pt_stall  (pt_stall),
        .pt        (pt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic longint clamp_coord(longint v);
        longint hi;
        longint lo;
        hi = longint'(pxr_pkg::COORD_MAX);
        lo = longint'(pxr_pkg::COORD_MIN);
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    function automatic longint scaled(longint d, longint t);
        return (d * t + (longint'(1) << (pxr_pkg::TF - 1))) >>> pxr_pkg::TF;
    endfunction

    function automatic pxr_pkg::result_t rotate_point(pxr_pkg::point_t p);
        longint x, y, z, px, py, c, s, dx, dy, nx, ny, nz;
        pxr_pkg::result_t r;
        x  = longint'(p.in_x);
        y  = longint'(p.in_y);
        z  = longint'(p.in_z);
        px = longint'(pivot_x_reg);
        py = longint'(pivot_y_reg);
        for (int axis = 0; axis < 3; axis++)
        begin
            c  = longint'(trig_reg[2 * axis]);
            s  = longint'(trig_reg[2 * axis + 1]);
            dx = x - px;
            dy = y - py;
            case (axis)
                0:
                begin
                    nx = dx;
                    ny = scaled(dy, c) + scaled(z, -s);
                    nz = scaled(dy, s) + scaled(z, c);
                end
                1:
                begin
                    nx = scaled(dx, c) + scaled(z, s);
                    ny = dy;
                    nz = scaled(dx, -s) + scaled(z, c);
                end
                default:
                begin
                    nx = scaled(dx, c) + scaled(dy, -s);
                    ny = scaled(dx, s) + scaled(dy, c);
                    nz = z;
                end
            endcase
            x = clamp_coord(nx + px);
            y = clamp_coord(ny + py);
            z = clamp_coord(nz);
        end
        r.out_x = pxr_pkg::coord_t'(x);
        r.out_y = pxr_pkg::coord_t'(y);
        return r;
    endfunction

    task automatic report(string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        fail_count++;
    endtask

    task automatic write_reg(pxr_pkg::cfg_reg_e idx, logic [pxr_pkg::CW-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            pxr_pkg::REG_PIVOT_X: pivot_x_reg = pxr_pkg::coord_t'(data);
            pxr_pkg::REG_PIVOT_Y: pivot_y_reg = pxr_pkg::coord_t'(data);
            default:              trig_reg[idx] = pxr_pkg::trig_t'(data[pxr_pkg::TW-1:0]);
        endcase
        @(negedge clk);
    endtask

    task automatic apply_config();
        for (int i = 0; i < 8; i++)
        begin
            write_reg(pxr_pkg::cfg_reg_e'(i), cfg_vals[i]);
        end
        cfg_write <= 1'b0;
    endtask

    function automatic logic [pxr_pkg::CW-1:0] pick_trig(cfg_kind_e kind);
        int t;
        case (kind)
            CFG_EXTREME: t = ($urandom_range(1) != 0) ? 16384 : -16384;
            CFG_RAW16:   t = int'($urandom_range(65535)) - 32768;
            default:     t = int'($urandom_range(32768)) - 16384;
        endcase
        return pxr_pkg::CW'(t);
    endfunction

    function automatic logic [pxr_pkg::CW-1:0] pick_pivot(cfg_kind_e kind);
        case (kind)
            CFG_EXTREME:
                return ($urandom_range(1) != 0) ? pxr_pkg::COORD_MAX : pxr_pkg::COORD_MIN;
            CFG_NEAR:    return pxr_pkg::CW'(int'($urandom_range(8191)) - 4096);
            default:     return pxr_pkg::CW'($urandom);
        endcase
    endfunction

    function automatic pxr_pkg::coord_t rand_coord();
        case ($urandom_range(9))
            0:       return pxr_pkg::COORD_MAX;
            1:       return pxr_pkg::COORD_MIN;
            2, 3, 4: return pxr_pkg::coord_t'(int'($urandom_range(8191)) - 4096);
            default: return pxr_pkg::coord_t'($urandom);
        endcase
    endfunction

    task automatic send_point(pxr_pkg::point_t p, pxr_pkg::result_t want, bit typed);
        pt_valid <= 1'b1;
        pt       <= p;
        do
        begin
            @(posedge clk);
        end
        while (pt_stall);
        pending_xy.push_back(typed ? want : rotate_point(p));
        @(negedge clk);
    endtask

    task automatic pace_sender();
        int gap;
        if (tx_style == TX_BURSTS)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(30, 1);
                gap = $urandom_range(8, 1);
                pt_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic drain();
        pt_valid <= 1'b0;
        while (pending_xy.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver stall pattern and long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_req != hold_done)
        begin
            hold_done++;
            hold_left = HOLD_LEN;
            res_stall <= 1'b1;
        end
        else
        begin
            case (rx_mode)
                RX_FREE:   res_stall <= 1'b0;
                RX_RANDOM: res_stall <= ($urandom_range(3) == 0);
                default:
                begin
                    if (run_left == 0)
                    begin
                        run_stall = !run_stall;
                        run_left  = $urandom_range(12, 1);
                    end
                    run_left--;
                    res_stall <= run_stall;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_xy.size() == 0)
            begin
                report($sformatf("unexpected transaction x=%h y=%h", res.out_x, res.out_y));
            end
            else
            begin
                oldest = pending_xy.pop_front();
                if (res.out_x !== oldest.out_x)
                begin
                    report($sformatf("out_x got %h want %h", res.out_x, oldest.out_x));
                end
                if (res.out_y !== oldest.out_y)
                begin
                    report($sformatf("out_y got %h want %h", res.out_y, oldest.out_y));
                end
            end
        end
    end

    initial
    begin
        pxr_pkg::point_t p;
        cfg_kind_e       kind;
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        pt_valid    = 1'b0;
        pt          = '0;
        res_stall   = 1'b0;
        fail_count  = 0;
        cycles      = 0;
        rx_mode     = RX_FREE;
        tx_style    = TX_STREAM;
        hold_req    = 0;
        hold_done   = 0;
        hold_left   = 0;
        run_left    = 0;
        run_stall   = 1'b0;
        burst_left  = 0;
        for (int i = 0; i < 6; i++)
        begin
            trig_reg[i] = (i % 2 == 0) ? pxr_pkg::TRIG_ONE : pxr_pkg::trig_t'(0);
        end
        pivot_x_reg = '0;
        pivot_y_reg = '0;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings first, then each directed setting over the same rows
        for (int row = 0; row < DIR_ROWS; row++)
        begin
            send_point(dir_tab[row].pnt, dir_tab[row].want, 1'b1);
        end
        rx_mode  = RX_RANDOM;
        tx_style = TX_BURSTS;
        for (int set = 0; set < DIR_SETS; set++)
        begin
            drain();
            cfg_vals = dir_cfg[set];
            apply_config();
            for (int row = 0; row < DIR_ROWS; row++)
            begin
                send_point(dir_tab[row].pnt, '0, 1'b0);
                pace_sender();
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                1, 9:    kind = CFG_EXTREME;
                5:       kind = CFG_RAW16;
                3, 7:    kind = CFG_NEAR;
                default: kind = CFG_RANDOM;
            endcase
            for (int i = 0; i < 6; i++)
            begin
                cfg_vals[i] = pick_trig(kind);
            end
            cfg_vals[pxr_pkg::REG_PIVOT_X] = pick_pivot(kind);
            cfg_vals[pxr_pkg::REG_PIVOT_Y] = pick_pivot(kind);
            apply_config();
            rx_mode  = rx_mode_e'(ph % 3);
            tx_style = (ph % 2 == 0) ? TX_BURSTS : TX_STREAM;
            if (ph == 2 || ph == 8)
            begin
                tx_style = TX_STREAM;
                hold_req++;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                p.in_x = rand_coord();
                p.in_y = rand_coord();
                p.in_z = rand_coord();
                send_point(p, '0, 1'b0);
                pace_sender();
            end
        end

        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
